### rtl/int_to_fullwidth_decimal_assert.svh
// ----------------------------------------------------------------------------
// int_to_fullwidth_decimal assertion macros
// concurrent checks on clk, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef INT_TO_FULLWIDTH_DECIMAL_ASSERT_SVH
`define INT_TO_FULLWIDTH_DECIMAL_ASSERT_SVH

`ifndef SYNTHESIS

// check held outside reset
`define ITFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check held on every edge, reset included
`define ITFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ITFD_ASSERT(lbl, prop, msg)
`define ITFD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/itfd_pkg.sv
// ----------------------------------------------------------------------------
// itfd_pkg
// constants and register codes for the full-width decimal converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itfd_pkg;

  // input word and field limits
  localparam int VALUE_BITS  = 32;
  localparam int MAX_DIGITS  = 31;
  localparam int MAG_BITS    = VALUE_BITS - 1;

  // decimal digits needed for the largest non-negative value
  localparam int BCD_DIGITS  = (MAG_BITS * 30103) / 100000 + 1;
  localparam int BCD_W       = BCD_DIGITS * 4;
  localparam int DIG_IDX_W   = $clog2(BCD_DIGITS);

  // shift-add-3 pipeline shape
  localparam int DAB_PER_STAGE = 4;
  localparam int N_STAGES      = (MAG_BITS + DAB_PER_STAGE - 1) / DAB_PER_STAGE;
  localparam int DAB_W         = BCD_W + MAG_BITS;

  // register widths and ranges
  localparam int POS_W       = 5;
  localparam int BYTES_W     = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int DIGIT_HIGH  = (MAX_DIGITS > 31) ? 31 : ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
  localparam int BYTES_LOW   = 3;
  localparam int BYTES_HIGH  = 64;
  localparam int DIGITS_RST  = 1;
  localparam int BYTES_RST   = 32;

  // shift-jis full-width digit code parts
  localparam logic [7:0] SJIS_HIGH       = 8'h82;
  localparam logic [7:0] SJIS_DIGIT_BASE = 8'h4F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIGIT_COUNT  = 2'd0,
    REG_OUTPUT_BYTES = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

### rtl/int_to_fullwidth_decimal.sv
// ----------------------------------------------------------------------------
// int_to_fullwidth_decimal
// signed integer to zero-padded full-width shift-jis decimal digits
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in       input      in_valid/in_ready  in_number_in
//  out      output     out_valid/out_ready out_sjis_code, out_last_digit
//  cfg      input      cfg_we             cfg_index, cfg_wdata
//
//  a word enters in any cycle the converter pipeline can move; the binary to
//  decimal conversion runs over N_STAGES register stages, four shift-add-3
//  steps each, three in the last. the digit serialiser then sends one digit
//  per cycle unless out_ready stalls it, so a word gives min(digit_count,
//  (output_bytes-1)/2) digits (1 to 31). with nothing ahead of it, the first
//  digit of a word passes the stages and the serialiser to the output register.
//  reset (synchronous, active low) empties the pipeline and output register
//  and sets the registers to 1 digit and 32 bytes; no clearing pass.
//  a stall on out_ready holds the serialiser and output register; the
//  stages keep moving until the last stage holds a word the serialiser
//  cannot take, then every stage holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "int_to_fullwidth_decimal_assert.svh"

module int_to_fullwidth_decimal (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input word
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [itfd_pkg::VALUE_BITS-1:0] in_number_in,
  // result word
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [15:0]                         out_sjis_code,
  output logic                                out_last_digit,
  // register writes
  input  wire logic                           cfg_we,
  input  wire logic [itfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [itfd_pkg::BYTES_W-1:0]   cfg_wdata
);

  import itfd_pkg::*;

  // configuration registers
  logic [POS_W-1:0]   digit_cnt_r;
  logic [BYTES_W-1:0] out_bytes_r;

  // conversion pipeline
  logic [DAB_W-1:0]    stage_r     [N_STAGES];
  logic [N_STAGES-1:0] stage_vld_r;
  logic [MAG_BITS-1:0] mag;
  logic                adv;
  logic                tail_vld;

  // digit serialiser
  logic [BCD_DIGITS-1:0][3:0] bcd_r;
  logic [POS_W-1:0]           pos_r;
  logic [POS_W-1:0]           remain_r;
  logic                       busy_r;
  logic                       emit;
  logic                       last_step;
  logic                       ser_load;
  logic [5:0]                 half;
  logic [POS_W-1:0]           shown;
  logic [3:0]                 dig;

  // output register
  logic        out_valid_r;
  logic [15:0] out_code_r;
  logic        out_last_r;

  // terms for the checks
  logic pipe_idle;
  logic code_ok;

  // four shift-add-3 steps, skipping steps past the magnitude width
  function automatic logic [DAB_W-1:0] dabble(input logic [DAB_W-1:0] x, input int first);
    logic [DAB_W-1:0] r;
    r = x;
    for (int k = 0; k < DAB_PER_STAGE; k++) begin
      if (first + k < MAG_BITS) begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
          if (r[MAG_BITS + 4*d +: 4] >= 4'd5) begin
            r[MAG_BITS + 4*d +: 4] = r[MAG_BITS + 4*d +: 4] + 4'd3;
          end
        end
        r = {r[DAB_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // register writes, saturated to range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_cnt_r <= POS_W'(DIGITS_RST);
      out_bytes_r <= BYTES_W'(BYTES_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIGIT_COUNT: begin
          if (cfg_wdata[POS_W-1:0] == '0) begin
            digit_cnt_r <= POS_W'(1);
          end else if (cfg_wdata[POS_W-1:0] > POS_W'(DIGIT_HIGH)) begin
            digit_cnt_r <= POS_W'(DIGIT_HIGH);
          end else begin
            digit_cnt_r <= cfg_wdata[POS_W-1:0];
          end
        end
        REG_OUTPUT_BYTES: begin
          if (cfg_wdata < BYTES_W'(BYTES_LOW)) begin
            out_bytes_r <= BYTES_W'(BYTES_LOW);
          end else if (cfg_wdata > BYTES_W'(BYTES_HIGH)) begin
            out_bytes_r <= BYTES_W'(BYTES_HIGH);
          end else begin
            out_bytes_r <= cfg_wdata;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // negative input counts as zero
  assign mag      = in_number_in[VALUE_BITS-1] ? '0 : in_number_in[MAG_BITS-1:0];
  assign tail_vld = stage_vld_r[N_STAGES-1];
  assign adv      = !tail_vld || ser_load;
  assign in_ready = adv;

  // conversion stages
  for (genvar s = 0; s < N_STAGES; s++) begin : g_stage
    logic [DAB_W-1:0] src;
    logic             src_vld;
    if (s == 0) begin : g_first
      assign src     = {{BCD_W{1'b0}}, mag};
      assign src_vld = in_valid;
    end else begin : g_next
      assign src     = stage_r[s-1];
      assign src_vld = stage_vld_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_vld_r[s] <= 1'b0;
      end else if (adv) begin
        stage_vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stage_r[s] <= dabble(src, s * DAB_PER_STAGE);
      end
    end
  end

  // digit count for the next word
  assign half  = 6'((out_bytes_r - BYTES_W'(1)) >> 1);
  assign shown = (half > {1'b0, digit_cnt_r}) ? digit_cnt_r : half[POS_W-1:0];

  // serialiser handshake
  assign emit      = busy_r && (!out_valid_r || out_ready);
  assign last_step = emit && (remain_r == POS_W'(1));
  assign ser_load  = tail_vld && (!busy_r || last_step);

  // digit at the current field position, leading positions read zero
  always_comb begin
    dig = 4'd0;
    if (pos_r < POS_W'(BCD_DIGITS)) begin
      dig = bcd_r[pos_r[DIG_IDX_W-1:0]];
    end
  end

  // serialiser control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ser_load) begin
      busy_r <= 1'b1;
    end else if (last_step) begin
      busy_r <= 1'b0;
    end
  end

  // serialiser data
  always_ff @(posedge clk) begin
    if (ser_load) begin
      bcd_r    <= stage_r[N_STAGES-1][DAB_W-1 -: BCD_W];
      pos_r    <= digit_cnt_r - POS_W'(1);
      remain_r <= shown;
    end else if (emit) begin
      pos_r    <= pos_r - POS_W'(1);
      remain_r <= remain_r - POS_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_code_r <= {SJIS_HIGH, SJIS_DIGIT_BASE + {4'd0, dig}};
      out_last_r <= (remain_r == POS_W'(1));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sjis_code  = out_code_r;
  assign out_last_digit = out_last_r;

  // nothing in flight, and a legal digit code
  assign pipe_idle = !out_valid_r && !busy_r && (stage_vld_r == '0);
  assign code_ok   = (out_code_r[15:8] == SJIS_HIGH)
                     && (out_code_r[7:0] >= SJIS_DIGIT_BASE)
                     && (out_code_r[7:0] <= SJIS_DIGIT_BASE + 8'd9);

  // checks
  `ITFD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> pipe_idle, "reset left a word in flight")
  `ITFD_ASSERT(a_busy_count, busy_r |-> remain_r != '0, "serialiser busy with no digits left")
  `ITFD_ASSERT(a_last_ends, last_step && !ser_load |=> !busy_r, "busy after the final digit")
  `ITFD_ASSERT(a_code_range, out_valid_r |-> code_ok, "digit code out of range")
  `ITFD_ASSERT(a_pipe_hold, !adv |=> $stable(stage_vld_r), "pipeline moved while stalled")

endmodule

`default_nettype wire

### tb/itfd_digit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfd_digit_checker
// follows register writes and the input channel, predicts the full-width
// digit words of every accepted number and compares them, in order, with the
// words taken from the result channel
// ----------------------------------------------------------------------------

module itfd_digit_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [itfd_pkg::VALUE_BITS-1:0] in_number_in,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [15:0]                         out_sjis_code,
  input  logic                                out_last_digit,
  input  logic                                cfg_we,
  input  logic [itfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [itfd_pkg::BYTES_W-1:0]        cfg_wdata,
  output int                                  error_count,
  output int                                  digits_pending
);

  typedef struct {
    logic [15:0] code;
    logic        last;
  } digit_word_t;

  // own copy of the two registers
  int field_digits_q;
  int buffer_bytes_q;

  digit_word_t expected_digits[$];

  initial begin
    error_count    = 0;
    digits_pending = 0;
    field_digits_q = itfd_pkg::DIGITS_RST;
    buffer_bytes_q = itfd_pkg::BYTES_RST;
  end

  function automatic int clamp(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // zero-padded field, then the leftmost digits that fit the buffer
  function automatic void queue_digits(input logic signed [itfd_pkg::VALUE_BITS-1:0] number);
    logic [63:0] mag;
    logic [3:0]  field_digit [itfd_pkg::DIGIT_HIGH];
    int          shown;
    digit_word_t w;
    mag = (number < 0) ? 64'd0 : 64'(number);
    shown = (buffer_bytes_q - 1) / 2;
    if (shown > field_digits_q) shown = field_digits_q;
    for (int i = field_digits_q - 1; i >= 0; i--) begin
      field_digit[i] = 4'(mag % 64'd10);
      mag = mag / 64'd10;
    end
    for (int i = 0; i < shown; i++) begin
      w.code = {itfd_pkg::SJIS_HIGH, itfd_pkg::SJIS_DIGIT_BASE + 8'(field_digit[i])};
      w.last = (i == shown - 1);
      expected_digits.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    digit_word_t want;
    if (!rst_n) begin
      field_digits_q = itfd_pkg::DIGITS_RST;
      buffer_bytes_q = itfd_pkg::BYTES_RST;
      expected_digits.delete();
    end else begin
      // register writes, saturated; unmapped indexes do nothing
      if (cfg_we) begin
        case (cfg_index)
          itfd_pkg::REG_DIGIT_COUNT:
            field_digits_q = clamp(int'(cfg_wdata[itfd_pkg::POS_W-1:0]), 1,
                                   itfd_pkg::DIGIT_HIGH);
          itfd_pkg::REG_OUTPUT_BYTES:
            buffer_bytes_q = clamp(int'(cfg_wdata), itfd_pkg::BYTES_LOW,
                                   itfd_pkg::BYTES_HIGH);
          default: ;
        endcase
      end
      // result side
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected word, expected none, got code %h last %b",
                   $time, out_sjis_code, out_last_digit);
          error_count++;
        end else begin
          want = expected_digits.pop_front();
          if (out_sjis_code !== want.code || out_last_digit !== want.last) begin
            $display("%0t: word mismatch, expected code %h last %b, got code %h last %b",
                     $time, want.code, want.last, out_sjis_code, out_last_digit);
            error_count++;
          end
        end
      end
      // input side
      if (in_valid && in_ready) queue_digits(in_number_in);
    end
    digits_pending = expected_digits.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives numbers and register settings into the full-width decimal
// converter under bursty input and a stalling receiver; the digit checker
// beside the block does the prediction and comparison
// ----------------------------------------------------------------------------

module testbench;

  localparam logic [itfd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [itfd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [itfd_pkg::VALUE_BITS-1:0] in_number_in = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [15:0] out_sjis_code;
  logic out_last_digit;
  logic cfg_we = 1'b0;
  logic [itfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [itfd_pkg::BYTES_W-1:0] cfg_wdata = '0;

  int error_count;
  int digits_pending;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_run = 0;
  int stall_tick = 0;

  int_to_fullwidth_decimal u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_number_in   (in_number_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sjis_code  (out_sjis_code),
    .out_last_digit (out_last_digit),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  itfd_digit_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_number_in   (in_number_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sjis_code  (out_sjis_code),
    .out_last_digit (out_last_digit),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .error_count    (error_count),
    .digits_pending (digits_pending)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // receiver: runs of always-ready, random stalls and a fixed duty pattern
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run  = $urandom_range(30, 200);
    end
    stall_run--;
    stall_tick++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ((stall_tick % 7) < 4);
    endcase
  end

  // one register write, then cfg_we is dropped before the task returns
  task automatic write_reg(input logic [itfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [itfd_pkg::BYTES_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // sender works in bursts with random gaps between them
  task automatic send_word(input logic signed [itfd_pkg::VALUE_BITS-1:0] number);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10);
    end
    in_valid     <= 1'b1;
    in_number_in <= number;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // let every expected word come out before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    while (digits_pending != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_number();
    logic [31:0] p;
    int          k;
    case ($urandom_range(0, 5))
      0: return {1'b1, 31'($urandom)};
      1: return $urandom_range(0, 99);
      2: begin
        // around a power of ten
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        return p - $urandom_range(0, 1);
      end
      3: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_setting();
    logic [itfd_pkg::BYTES_W-1:0] dw;
    logic [itfd_pkg::BYTES_W-1:0] bw;
    case ($urandom_range(0, 4))
      0: dw = 7'd0;
      1: dw = 7'd31;
      2: dw = 7'd1;
      default: dw = 7'($urandom_range(0, 127));
    endcase
    case ($urandom_range(0, 4))
      0: bw = 7'($urandom_range(0, 3));
      1: bw = 7'($urandom_range(64, 127));
      default: bw = 7'($urandom_range(0, 127));
    endcase
    write_reg(itfd_pkg::REG_DIGIT_COUNT, dw);
    write_reg(itfd_pkg::REG_OUTPUT_BYTES, bw);
    if ($urandom_range(0, 2) == 0)
      write_reg(($urandom_range(0, 1) != 0) ? REG_UNMAPPED_A : REG_UNMAPPED_B,
                7'($urandom_range(0, 127)));
  endtask

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: one digit shown, the units digit
    send_word(0);
    send_word(7);
    send_word(32'sh7FFF_FFFF);
    send_word(-1);
    drain();

    // widest field, largest buffer; upper data bits dropped on the digit count
    write_reg(itfd_pkg::REG_DIGIT_COUNT, 7'h7F);
    write_reg(itfd_pkg::REG_OUTPUT_BYTES, 7'h7F);
    send_word(32'sh7FFF_FFFF);
    send_word(32'sh8000_0000);
    send_word(1000000000);
    send_word(1);
    drain();

    // below range on both registers, then writes to unmapped indexes
    write_reg(itfd_pkg::REG_DIGIT_COUNT, 7'd0);
    write_reg(itfd_pkg::REG_OUTPUT_BYTES, 7'd2);
    send_word(9);
    send_word(2147483640);
    drain();
    write_reg(REG_UNMAPPED_A, 7'h55);
    write_reg(REG_UNMAPPED_B, 7'h2A);
    send_word(5);
    drain();

    // field narrower than the number, high digit-count bits ignored
    write_reg(itfd_pkg::REG_DIGIT_COUNT, 7'h44);
    write_reg(itfd_pkg::REG_OUTPUT_BYTES, 7'd65);
    send_word(123456789);
    send_word(98765);
    drain();

    // buffer limits the digits shown; leading zeros of a wide field
    write_reg(itfd_pkg::REG_DIGIT_COUNT, 7'd20);
    write_reg(itfd_pkg::REG_OUTPUT_BYTES, 7'd9);
    send_word(32'sh7FFF_FFFF);
    send_word(42);
    drain();
    write_reg(itfd_pkg::REG_DIGIT_COUNT, 7'd12);
    write_reg(itfd_pkg::REG_OUTPUT_BYTES, 7'd1);
    send_word(999999999);
    send_word(-12345);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_setting();
      repeat (WORDS_PER_PHASE) send_word(pick_number());
      drain();
    end

    // tail for anything late out of the pipeline
    repeat (40) @(negedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
